### rtl/grc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray caster
// Payload structs, register indexes, datapath widths and map constants.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_DIM      = 64;
  localparam int MAP_AW       = $clog2(MAP_DIM);
  localparam int STEP_MAX     = 2 * MAP_DIM;
  localparam int STEP_W       = $clog2(STEP_MAX);
  localparam logic [7:0] PASSABLE_CODE = 8'd5;

  localparam int FRAC_W   = 16;
  localparam int FRAC_ONE = 65536;
  localparam int DIV_NW   = 33;   // dividend and quotient width
  localparam int DIV_DW   = 48;   // divisor width
  localparam int DELTA_W  = 41;   // holds the 2^40 no-crossing distance
  localparam int DIST_W   = 49;   // side distances after the longest walk
  localparam int RAY_W    = 31;
  localparam int CAM_W    = 29;
  localparam int CRD_W    = MAP_AW + 3;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 22;

  localparam logic [CFG_IW-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [CFG_IW-1:0] REG_WIDTH   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_HEIGHT  = 3'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_value;
    logic [9:0] column;
  } grc_in_t;

  typedef struct packed {
    logic [9:0] out_column;
    logic [9:0] draw_start;
    logic [9:0] draw_end;
    logic [7:0] wall_code;
    logic       hit_side;
    logic       no_hit;
  } grc_out_t;

endpackage

### rtl/grc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div: shared restoring divider
// Unsigned division, one quotient bit per cycle, done pulses when the
// quotient is complete. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module grc_div
  import grc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NW);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_DW'(trial - {1'b0, dsr_r}) : trial[DIV_DW-1:0];
        quo_r <= {quo_r[DIV_NW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/grid_ray_cast_column_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_cast_column_top: DDA ray caster over a 64 x 64 cell map
// Holds the map in a synchronous RAM, casts one screen column per request and
// returns the wall code, hit side and clamped slice rows.
// ----------------------------------------------------------------------------
// Channel  Ports                          Direction  Carries
// in       in_valid in_ready in_data      input      cell write or column cast
// out      out_valid out_ready out_data   output     one result per cast
// cfg      cfg_valid cfg_ready cfg_index  input      register writes
//          cfg_data
//
// A cell write is taken in the idle state. A cast runs three divider passes
// (camera, two reciprocals), the setup states and a map RAM read per DDA
// step, plus a fourth divider pass for the slice height when a wall is hit
// at a nonzero perpendicular distance. After reset a clearing pass zeroes
// all 4096 map cells; in_ready stays low meanwhile, configuration writes
// are taken at all times.
// The result sits in an output register, so a stalled output does not hold
// back the next input transfer, only the completion of the next cast.
// ----------------------------------------------------------------------------
module grid_ray_cast_column_top
  import grc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  grc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output grc_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int MEM_AW = 2 * MAP_AW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_RAYMUL, ST_RAYADD, ST_DX, ST_DY,
    ST_SIDEMUL, ST_STEP, ST_CHECK, ST_LINE, ST_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [21:0]        pos_x_r, pos_y_r;
  logic signed [17:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [9:0]         width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 22'd131072;
      pos_y_r   <= 22'd131072;
      dir_x_r   <= 18'sd65536;
      dir_y_r   <= 18'sd0;
      plane_x_r <= 18'sd0;
      plane_y_r <= -18'sd43254;
      width_r   <= 10'd320;
      height_r  <= 10'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POS_X:   pos_x_r   <= cfg_data;
        REG_POS_Y:   pos_y_r   <= cfg_data;
        REG_DIR_X:   dir_x_r   <= cfg_data[17:0];
        REG_DIR_Y:   dir_y_r   <= cfg_data[17:0];
        REG_PLANE_X: plane_x_r <= cfg_data[17:0];
        REG_PLANE_Y: plane_y_r <= cfg_data[17:0];
        REG_WIDTH:   width_r   <= cfg_data[9:0];
        REG_HEIGHT:  height_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [9:0] w_eff, h_eff;
  assign w_eff = (width_r == '0) ? 10'd1 : width_r;
  assign h_eff = (height_r == '0) ? 10'd1 : height_r;

  // Map RAM.
  logic [7:0]        grid_mem [MAP_DIM*MAP_DIM];
  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data_r;
  logic [MEM_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    rd_data_r <= grid_mem[rd_addr];
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = 8'd0;
    end else begin
      wr_en   = in_valid && in_ready && (in_data.opcode == OP_WRITE);
      wr_addr = {in_data.cell_x, in_data.cell_y};
      wr_data = in_data.cell_value;
    end
  end

  // Divider.
  logic              div_start_r;
  logic              div_start_nxt;
  logic [DIV_NW-1:0] div_a_r;
  logic [DIV_DW-1:0] div_b_r;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  grc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Datapath state.
  logic [9:0]              col_r;
  logic signed [CAM_W-1:0] cam_r;
  logic signed [46:0]      prodx_r, prody_r;
  logic signed [RAY_W-1:0] rdx_r, rdy_r;
  logic [DELTA_W-1:0]      dx_r, dy_r;
  logic [DIST_W-1:0]       sx_r, sy_r;
  logic signed [CRD_W-1:0] mx_r, my_r;
  logic [STEP_W-1:0]       n_r;
  logic                    side_r;
  logic                    hit_r;
  logic [7:0]              code_r;
  logic [9:0]              line_r;
  logic                    out_valid_r;
  grc_out_t                out_data_r;

  logic signed [RAY_W-1:0] rdx_nxt, rdy_nxt;
  logic [RAY_W-1:0]        rdx_abs, rdy_abs;
  logic [16:0]             fx_sel, fy_sel;
  logic [49:0]             sx_prod, sy_prod;
  logic                    step_x;
  logic signed [CRD_W-1:0] mx_nxt, my_nxt;
  logic                    out_of_map;
  logic                    start_out;
  logic [DIST_W-1:0]       perp;
  logic                    is_wall;
  logic [9:0]              half, line_half, ds;
  logic [10:0]             de_sum;
  logic [9:0]              de;

  assign rdx_nxt = dir_x_r + RAY_W'(prodx_r >>> FRAC_W);
  assign rdy_nxt = dir_y_r + RAY_W'(prody_r >>> FRAC_W);
  assign rdx_abs = rdx_nxt[RAY_W-1] ? RAY_W'(-rdx_nxt) : RAY_W'(rdx_nxt);
  assign rdy_abs = rdy_nxt[RAY_W-1] ? RAY_W'(-rdy_nxt) : RAY_W'(rdy_nxt);

  assign fx_sel = rdx_r[RAY_W-1] ? {1'b0, pos_x_r[15:0]} : 17'(FRAC_ONE) - pos_x_r[15:0];
  assign fy_sel = rdy_r[RAY_W-1] ? {1'b0, pos_y_r[15:0]} : 17'(FRAC_ONE) - pos_y_r[15:0];

  // A finite delta fits in 33 bits; the no-crossing delta of 2^40 is a shift.
  assign sx_prod = fx_sel * dx_r[32:0];
  assign sy_prod = fy_sel * dy_r[32:0];

  assign start_out = (CRD_W'(pos_x_r[21:16]) >= CRD_W'(MAP_DIM)) ||
                     (CRD_W'(pos_y_r[21:16]) >= CRD_W'(MAP_DIM));

  // The y axis advances on a tie.
  assign step_x = sx_r < sy_r;
  assign mx_nxt = step_x ? (rdx_r[RAY_W-1] ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
  assign my_nxt = step_x ? my_r : (rdy_r[RAY_W-1] ? my_r - 1'b1 : my_r + 1'b1);
  assign out_of_map = mx_nxt[CRD_W-1] || my_nxt[CRD_W-1] ||
                      (mx_nxt >= CRD_W'(MAP_DIM)) || (my_nxt >= CRD_W'(MAP_DIM));
  assign rd_addr = {mx_nxt[MAP_AW-1:0], my_nxt[MAP_AW-1:0]};

  assign perp    = side_r ? sy_r - DIST_W'(dy_r) : sx_r - DIST_W'(dx_r);
  assign is_wall = (rd_data_r != 8'd0) && (rd_data_r != PASSABLE_CODE);

  assign half      = h_eff >> 1;
  assign line_half = line_r >> 1;
  assign ds        = half - line_half;
  assign de_sum    = {1'b0, half} + {1'b0, line_half};
  assign de        = (de_sum > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1 : de_sum[9:0];

  always_comb begin
    unique case (state_r)
      ST_IDLE:   div_start_nxt = in_valid && (in_data.opcode == OP_CAST);
      ST_RAYADD: div_start_nxt = 1'b1;
      ST_DX:     div_start_nxt = div_done;
      ST_CHECK:  div_start_nxt = is_wall && (perp != '0);
      default:   div_start_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      hit_r       <= 1'b0;
    end else begin
      div_start_r <= div_start_nxt;
      if (out_valid_r && out_ready && state_r != ST_FINISH) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == MEM_AW'(MAP_DIM*MAP_DIM - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_data.opcode == OP_CAST) begin
            col_r       <= in_data.column;
            div_a_r     <= DIV_NW'({in_data.column, 17'd0});
            div_b_r     <= DIV_DW'(w_eff);
            state_r     <= ST_CAM;
          end
        end
        ST_CAM: begin
          if (div_done) begin
            cam_r   <= $signed({1'b0, div_quo[CAM_W-2:0]}) - $signed(CAM_W'(FRAC_ONE));
            state_r <= ST_RAYMUL;
          end
        end
        ST_RAYMUL: begin
          prodx_r <= plane_x_r * cam_r;
          prody_r <= plane_y_r * cam_r;
          state_r <= ST_RAYADD;
        end
        ST_RAYADD: begin
          rdx_r       <= rdx_nxt;
          rdy_r       <= rdy_nxt;
          div_a_r     <= DIV_NW'(64'h1_0000_0000);
          div_b_r     <= DIV_DW'(rdx_abs);
          state_r     <= ST_DX;
        end
        ST_DX: begin
          if (div_done) begin
            dx_r        <= (rdx_r == '0) ? DELTA_W'(64'h100_0000_0000) : DELTA_W'(div_quo);
            div_b_r     <= rdy_r[RAY_W-1] ? DIV_DW'(-rdy_r) : DIV_DW'(rdy_r);
            state_r     <= ST_DY;
          end
        end
        ST_DY: begin
          if (div_done) begin
            dy_r    <= (rdy_r == '0) ? DELTA_W'(64'h100_0000_0000) : DELTA_W'(div_quo);
            state_r <= ST_SIDEMUL;
          end
        end
        ST_SIDEMUL: begin
          sx_r    <= dx_r[DELTA_W-1] ? DIST_W'({fx_sel, 24'd0}) : DIST_W'(sx_prod >> FRAC_W);
          sy_r    <= dy_r[DELTA_W-1] ? DIST_W'({fy_sel, 24'd0}) : DIST_W'(sy_prod >> FRAC_W);
          mx_r    <= CRD_W'(pos_x_r[21:16]);
          my_r    <= CRD_W'(pos_y_r[21:16]);
          n_r     <= '0;
          hit_r   <= 1'b0;
          state_r <= start_out ? ST_FINISH : ST_STEP;
        end
        ST_STEP: begin
          if (step_x) sx_r <= sx_r + DIST_W'(dx_r);
          else        sy_r <= sy_r + DIST_W'(dy_r);
          mx_r    <= mx_nxt;
          my_r    <= my_nxt;
          side_r  <= !step_x;
          state_r <= out_of_map ? ST_FINISH : ST_CHECK;
        end
        ST_CHECK: begin
          code_r <= rd_data_r;
          if (is_wall) begin
            hit_r <= 1'b1;
            if (perp == '0) begin
              line_r  <= h_eff;
              state_r <= ST_FINISH;
            end else begin
              div_a_r     <= DIV_NW'({h_eff, 16'd0});
              div_b_r     <= perp[DIV_DW-1:0];
              state_r     <= ST_LINE;
            end
          end else if (n_r == STEP_W'(STEP_MAX - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= ST_STEP;
          end
        end
        ST_LINE: begin
          if (div_done) begin
            line_r  <= (div_quo > DIV_NW'(h_eff)) ? h_eff : div_quo[9:0];
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r           <= 1'b1;
            out_data_r.out_column <= col_r;
            out_data_r.draw_start <= hit_r ? ds : 10'd0;
            out_data_r.draw_end   <= hit_r ? de : 10'd0;
            out_data_r.wall_code  <= hit_r ? code_r : 8'd0;
            out_data_r.hit_side   <= hit_r ? side_r : 1'b0;
            out_data_r.no_hit     <= !hit_r;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input ready during map clearing");

  a_no_hit_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_hit) |->
      (out_data.draw_start == '0 && out_data.wall_code == '0 && !out_data.hit_side))
    else $error("no-hit result carries wall fields");

  a_slice_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.no_hit) |-> (out_data.draw_start <= out_data.draw_end))
    else $error("slice start below slice end");

  a_div_start_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (state_r == ST_CAM || state_r == ST_DX || state_r == ST_DY ||
                     state_r == ST_LINE))
    else $error("divider started outside a division state");

endmodule
